// ----- rtl/wrsi_pkg.sv -----
// Shared constants, types and helpers for the windowed RSI order signal.
// No dependencies; every other file in rtl/ but wrsi_ram imports this package.
`default_nettype none
package wrsi_pkg;

  localparam int NUM_VENUES   = 8;
  localparam int MAX_WINDOW   = 64;
  localparam int PRICE_BITS   = 32;

  localparam int VENUE_FIELD_W = 3;
  localparam int VIDX_W     = (NUM_VENUES > 1) ? $clog2(NUM_VENUES) : 1;
  localparam int POS_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 2);
  localparam int DIFF_W     = PRICE_BITS + 1;
  localparam int SUM_W      = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int TOT_W      = SUM_W + 1;
  localparam int LEVEL_W    = 7;
  localparam int G100_W     = SUM_W + LEVEL_W;
  localparam int PROD_W     = TOT_W + LEVEL_W;
  localparam int RING_AW    = VIDX_W + POS_W;
  localparam int RING_DEPTH = 1 << RING_AW;
  localparam int RSI_SCALE  = 100;

  localparam logic [VENUE_FIELD_W:0] VENUE_LIMIT = (VENUE_FIELD_W + 1)'(NUM_VENUES);

  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH  = 2'd0,
    REG_BUY_LEVEL      = 2'd1,
    REG_SELL_LEVEL     = 2'd2,
    REG_ORDER_QUANTITY = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } side_t;

  typedef struct packed {
    logic [VENUE_FIELD_W-1:0] venue;
    logic [15:0]              symbol;
    logic [31:0]              price;
    logic [47:0]              exch_ms;
    logic [47:0]              ingest_ms;
  } tick_tag_t;

  typedef struct packed {
    logic             elig;
    logic [SUM_W-1:0] gain;
    logic [SUM_W-1:0] loss;
    tick_tag_t        tag;
  } win_item_t;

  // zero acts as one, anything past the ring depth is clipped
  function automatic logic [CNT_W-1:0] eff_window(input logic [LEVEL_W-1:0] wl);
    logic [CNT_W-1:0] wx;
    wx = CNT_W'(wl);
    if (wx == '0) begin
      return CNT_W'(1);
    end else if (wx > CNT_W'(MAX_WINDOW)) begin
      return CNT_W'(MAX_WINDOW);
    end
    return wx;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/wrsi_tick_if.sv -----
// Tick input channel: valid/ready handshake plus the tick word.
// Depends on wrsi_pkg.
`default_nettype none
interface wrsi_tick_if;
  import wrsi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [VENUE_FIELD_W-1:0] venue_index;
  logic [15:0]              symbol_tag;
  logic [31:0]              tick_price;
  logic [47:0]              exchange_time_ms;
  logic [47:0]              ingest_time_ms;

  modport source (output valid, venue_index, symbol_tag, tick_price,
                  exchange_time_ms, ingest_time_ms, input ready);
  modport sink   (input valid, venue_index, symbol_tag, tick_price,
                  exchange_time_ms, ingest_time_ms, output ready);
endinterface
`default_nettype wire

// ----- rtl/wrsi_order_if.sv -----
// Order output channel: valid/ready handshake plus the order word.
// Depends on wrsi_pkg.
`default_nettype none
interface wrsi_order_if;
  import wrsi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     order_side;
  logic [VENUE_FIELD_W-1:0] order_venue;
  logic [15:0]              order_symbol;
  logic [31:0]              order_price;
  logic [31:0]              order_size;
  logic [31:0]              order_number;
  logic [47:0]              order_exchange_ms;
  logic [47:0]              order_ingest_ms;

  modport source (output valid, order_side, order_venue, order_symbol, order_price,
                  order_size, order_number, order_exchange_ms, order_ingest_ms,
                  input ready);
  modport sink   (input valid, order_side, order_venue, order_symbol, order_price,
                  order_size, order_number, order_exchange_ms, order_ingest_ms,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/wrsi_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first on a same-address access. No dependencies.
`default_nettype none
module wrsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/wrsi_window.sv -----
// Per-venue window: last price, ring position, fill count, difference ring
// and running gain/loss sums. Depends on wrsi_pkg, wrsi_tick_if, wrsi_ram.
`default_nettype none
module wrsi_window (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     clear,
  input  wire logic [wrsi_pkg::CNT_W-1:0] win,
  wrsi_tick_if.sink                     tick,
  output      logic                     item_valid,
  output      wrsi_pkg::win_item_t      item,
  input  wire logic                     item_ready
);
  import wrsi_pkg::*;

  logic [PRICE_BITS-1:0] prev [NUM_VENUES];
  logic [POS_W-1:0]      rpos [NUM_VENUES];
  logic [CNT_W-1:0]      fill [NUM_VENUES];
  logic [SUM_W-1:0]      gain [NUM_VENUES];
  logic [SUM_W-1:0]      loss [NUM_VENUES];

  logic [VIDX_W-1:0]     vi;
  logic                  in_range;
  logic [PRICE_BITS-1:0] price;
  logic                  first;
  logic [POS_W-1:0]      pos;
  logic [CNT_W-1:0]      held;
  logic                  evict;
  logic [CNT_W-1:0]      fill_nx;
  logic [CNT_W-1:0]      pos_inc;
  logic [POS_W-1:0]      pos_nx;
  logic [DIFF_W-1:0]     diff;
  logic                  full;
  logic                  accept;
  logic                  upd;
  logic                  ring_we;

  logic                  s1_valid;
  logic                  s1_act;
  logic                  s1_evict;
  logic                  s1_full;
  logic [DIFF_W-1:0]     s1_diff;
  tick_tag_t             s1_tag;
  logic [DIFF_W-1:0]     old_diff;
  logic [VIDX_W-1:0]     s1_v;
  logic                  s1_move;

  logic [DIFF_W-1:0]     d_neg;
  logic [DIFF_W-1:0]     o_neg;
  logic                  d_pos;
  logic                  o_pos;
  logic [PRICE_BITS-1:0] d_mag;
  logic [PRICE_BITS-1:0] o_mag;
  logic [SUM_W-1:0]      gain_add, gain_sub, loss_add, loss_sub;
  logic [SUM_W-1:0]      g_new, l_new;

  // accept stage
  assign vi       = tick.venue_index[VIDX_W-1:0];
  assign in_range = {1'b0, tick.venue_index} < VENUE_LIMIT;
  assign price    = tick.tick_price[PRICE_BITS-1:0];
  assign first    = (fill[vi] == '0);
  assign pos      = (CNT_W'(rpos[vi]) < win) ? rpos[vi] : '0;
  assign held     = fill[vi] - 1'b1;
  assign evict    = held >= win;
  assign fill_nx  = evict ? fill[vi] : fill[vi] + 1'b1;
  assign pos_inc  = CNT_W'(pos) + 1'b1;
  assign pos_nx   = (pos_inc >= win) ? '0 : pos_inc[POS_W-1:0];
  assign diff     = {1'b0, price} - {1'b0, prev[vi]};
  assign full     = fill_nx > win;

  assign tick.ready = !s1_valid || item_ready;
  assign accept     = tick.valid && tick.ready;
  assign upd        = accept && in_range;
  assign ring_we    = upd && !first;

  wrsi_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr ({vi, pos}),
    .wdata (diff),
    .re    (ring_we),
    .raddr ({vi, pos}),
    .rdata (old_diff)
  );

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < NUM_VENUES; i++) begin
        prev[i] <= '0;
        rpos[i] <= '0;
        fill[i] <= '0;
      end
    end else if (upd) begin
      prev[vi] <= price;
      if (first) begin
        fill[vi] <= CNT_W'(1);
      end else begin
        fill[vi] <= fill_nx;
        rpos[vi] <= pos_nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready) begin
      s1_act          <= in_range && !first;
      s1_evict        <= evict;
      s1_full         <= full;
      s1_diff         <= diff;
      s1_tag.venue    <= tick.venue_index;
      s1_tag.symbol   <= tick.symbol_tag;
      s1_tag.price    <= 32'(price);
      s1_tag.exch_ms  <= tick.exchange_time_ms;
      s1_tag.ingest_ms <= tick.ingest_time_ms;
    end
  end

  // sum update stage
  assign s1_v    = s1_tag.venue[VIDX_W-1:0];
  assign s1_move = s1_valid && item_ready;

  assign d_neg = '0 - s1_diff;
  assign o_neg = '0 - old_diff;
  assign d_pos = !s1_diff[DIFF_W-1] && (s1_diff != '0);
  assign o_pos = !old_diff[DIFF_W-1] && (old_diff != '0);
  assign d_mag = s1_diff[DIFF_W-1] ? d_neg[PRICE_BITS-1:0] : s1_diff[PRICE_BITS-1:0];
  assign o_mag = old_diff[DIFF_W-1] ? o_neg[PRICE_BITS-1:0] : old_diff[PRICE_BITS-1:0];

  assign gain_add = d_pos ? SUM_W'(d_mag) : '0;
  assign loss_add = d_pos ? '0 : SUM_W'(d_mag);
  assign gain_sub = (s1_evict && o_pos) ? SUM_W'(o_mag) : '0;
  assign loss_sub = (s1_evict && !o_pos) ? SUM_W'(o_mag) : '0;
  assign g_new    = gain[s1_v] + gain_add - gain_sub;
  assign l_new    = loss[s1_v] + loss_add - loss_sub;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < NUM_VENUES; i++) begin
        gain[i] <= '0;
        loss[i] <= '0;
      end
    end else if (s1_move && s1_act) begin
      gain[s1_v] <= g_new;
      loss[s1_v] <= l_new;
    end
  end

  assign item_valid = s1_valid;
  assign item.elig  = s1_act && s1_full;
  assign item.gain  = g_new;
  assign item.loss  = l_new;
  assign item.tag   = s1_tag;
endmodule
`default_nettype wire

// ----- rtl/wrsi_decide.sv -----
// RSI threshold test by cross-multiplication, order numbering and the
// output word register. Depends on wrsi_pkg, wrsi_order_if.
`default_nettype none
module wrsi_decide (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire wrsi_pkg::win_item_t           in_item,
  output      logic                          in_ready,
  input  wire logic [wrsi_pkg::LEVEL_W-1:0]  buy_level,
  input  wire logic [wrsi_pkg::LEVEL_W-1:0]  sell_level,
  input  wire logic [31:0]                   order_quantity,
  wrsi_order_if.source                       order
);
  import wrsi_pkg::*;

  logic              v2, v3, v4;
  win_item_t         it2;
  logic [G100_W-1:0] g100_3, g100_4;
  logic [TOT_W-1:0]  sum3;
  logic              elig3, elig4, nz4;
  tick_tag_t         tag3, tag4;
  logic [PROD_W-1:0] pb4, ps4;
  logic              ready2, ready3, ready4, ofree;
  logic              want_buy, want_sell, issue;
  logic [31:0]       orders;

  logic              ovalid;
  side_t             oside;
  tick_tag_t         otag;
  logic [31:0]       osize;
  logic [31:0]       onum;

  assign ofree    = !ovalid || order.ready;
  assign ready4   = !v4 || ofree;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign in_ready = ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready2) v2 <= in_valid;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      it2 <= in_item;
    end
    if (ready3) begin
      g100_3 <= G100_W'(it2.gain) * G100_W'(RSI_SCALE);
      sum3   <= TOT_W'(it2.gain) + TOT_W'(it2.loss);
      elig3  <= it2.elig;
      tag3   <= it2.tag;
    end
    if (ready4) begin
      g100_4 <= g100_3;
      pb4    <= PROD_W'(sum3) * PROD_W'(buy_level);
      ps4    <= PROD_W'(sum3) * PROD_W'(sell_level);
      nz4    <= (sum3 != '0);
      elig4  <= elig3;
      tag4   <= tag3;
    end
  end

  // buy has priority when both levels trip
  assign want_buy  = PROD_W'(g100_4) < pb4;
  assign want_sell = PROD_W'(g100_4) > ps4;
  assign issue     = v4 && elig4 && nz4 && (want_buy || want_sell);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      orders <= '0;
    end else if (ofree) begin
      ovalid <= issue;
      if (issue) begin
        orders <= orders + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ofree && issue) begin
      oside <= want_buy ? SIDE_BUY : SIDE_SELL;
      otag  <= tag4;
      osize <= order_quantity;
      onum  <= orders + 32'd1;
    end
  end

  assign order.valid             = ovalid;
  assign order.order_side        = oside;
  assign order.order_venue       = otag.venue;
  assign order.order_symbol      = otag.symbol;
  assign order.order_price       = otag.price;
  assign order.order_size        = osize;
  assign order.order_number      = onum;
  assign order.order_exchange_ms = otag.exch_ms;
  assign order.order_ingest_ms   = otag.ingest_ms;
endmodule
`default_nettype wire

// ----- rtl/windowed_rsi_order_signal.sv -----
// Windowed RSI order signal: per-venue RSI over a sliding window of price
// moves, issuing buy/sell order words. One tick word per clock sustained while
// the order output is not stalled; an accepted tick's order word passes the
// 5-register path (accept, sum update, scale, level products, output register).
// Synchronous reset restores register defaults and clears all windows, sums
// and the order counter; the difference ring needs no clearing pass.
// Depends on wrsi_pkg, wrsi_tick_if, wrsi_order_if, wrsi_window, wrsi_decide.
`default_nettype none
module windowed_rsi_order_signal (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  wrsi_tick_if.sink        tick,
  wrsi_order_if.source     order
);
  import wrsi_pkg::*;

  logic [LEVEL_W-1:0] window_length;
  logic [LEVEL_W-1:0] buy_level;
  logic [LEVEL_W-1:0] sell_level;
  logic [31:0]        order_quantity;
  logic               clear;
  logic [CNT_W-1:0]   win;
  logic               item_valid;
  logic               item_ready;
  win_item_t          item;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= LEVEL_W'(14);
      buy_level      <= LEVEL_W'(30);
      sell_level     <= LEVEL_W'(70);
      order_quantity <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LENGTH:  window_length  <= cfg_data[LEVEL_W-1:0];
        REG_BUY_LEVEL:      buy_level      <= cfg_data[LEVEL_W-1:0];
        REG_SELL_LEVEL:     sell_level     <= cfg_data[LEVEL_W-1:0];
        REG_ORDER_QUANTITY: order_quantity <= cfg_data;
        default: ;
      endcase
    end
  end

  assign clear = cfg_we && (cfg_reg_t'(cfg_index) == REG_WINDOW_LENGTH);
  assign win   = eff_window(window_length);

  wrsi_window u_window (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .win        (win),
    .tick       (tick),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  wrsi_decide u_decide (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (item_valid),
    .in_item        (item),
    .in_ready       (item_ready),
    .buy_level      (buy_level),
    .sell_level     (sell_level),
    .order_quantity (order_quantity),
    .order          (order)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !order.valid)
    else $error("order word valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !order.valid |-> tick.ready)
    else $error("tick stalled with empty output register");

  a_number_step: assert property (@(posedge clk) disable iff (rst)
    (order.valid && order.ready) |=>
      (!order.valid || order.order_number == $past(order.order_number) + 32'd1))
    else $error("order numbers not consecutive");
endmodule
`default_nettype wire

// ----- tb/sv/tb_windowed_rsi_order_signal.sv -----
`timescale 1ns / 1ps
// Self-checking bench for windowed_rsi_order_signal: per-venue RSI predictor,
// randomized trend ticks, random handshake gaps and order-by-order compare.
// Depends on wrsi_pkg, wrsi_tick_if, wrsi_order_if and the RTL top.
module tb_windowed_rsi_order_signal;
  import wrsi_pkg::*;

  localparam int    STALL_LIMIT  = 4000;
  localparam int    SETTLE_CYCLES = 12;
  localparam int    PHASE_TICKS  = 215;
  localparam longint PX_MAX      = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    side_t                    side;
    logic [VENUE_FIELD_W-1:0] venue;
    logic [15:0]              symbol;
    logic [31:0]              price, size, number;
    logic [47:0]              exch_ms, ingest_ms;
  } order_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  wrsi_tick_if  tick_ch ();
  wrsi_order_if order_ch ();

  windowed_rsi_order_signal uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .order     (order_ch)
  );

  // predictor state
  logic [LEVEL_W-1:0]       win_len, buy_lvl, sell_lvl;
  logic [31:0]              qty;
  logic [31:0]              last_px [NUM_VENUES];
  logic signed [DIFF_W-1:0] moves [NUM_VENUES][MAX_WINDOW];
  int unsigned              slot [NUM_VENUES];
  int unsigned              seen [NUM_VENUES];
  logic [SUM_W-1:0]         up_sum [NUM_VENUES];
  logic [SUM_W-1:0]         down_sum [NUM_VENUES];
  logic [31:0]              order_count;

  tick_tag_t   ticks_pending [$];
  order_word_t orders_expected [$];
  tick_tag_t   cur_tick;
  bit          tick_fire;
  bit          tick_hold;

  int unsigned src_idle_pct, sink_idle_pct;
  int unsigned ticks_taken, orders_checked, buys_seen, sells_seen, mismatches;
  int unsigned stall_cycles;

  logic [31:0] walk_px [NUM_VENUES];
  int          walk_drift [NUM_VENUES];

  int unsigned plan_win  [8] = '{14, 1, 64, 0, 127, 5, 3, 30};
  int unsigned plan_buy  [8] = '{30, 40, 45, 100, 127, 0, 50, 35};
  int unsigned plan_sell [8] = '{70, 60, 55, 0, 127, 100, 50, 65};
  int unsigned plan_span [8] = '{8, 8, 2, 8, 8, 8, 4, 3};

  int unsigned dir_venue [25] = '{0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2, 2, 2,
                                  3, 3, 4, 4, 5, 5, 6, 6, 7, 7};
  logic [31:0] dir_px [25] = '{100, 110, 120, 120, 120,
                               32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF,
                               1000, 1100, 1000, 1050, 1000, 900,
                               0, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                               7, 7, 1, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFE};

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void clear_windows();
    for (int v = 0; v < NUM_VENUES; v++) begin
      last_px[v]  = '0;
      slot[v]     = 0;
      seen[v]     = 0;
      up_sum[v]   = '0;
      down_sum[v] = '0;
    end
  endfunction

  function automatic void book_move(int unsigned v, logic signed [DIFF_W-1:0] d, bit add);
    logic [SUM_W-1:0] mag;
    mag = d[DIFF_W-1] ? SUM_W'(-d) : SUM_W'(d);
    if (d > 0) begin
      up_sum[v] = add ? up_sum[v] + mag : up_sum[v] - mag;
    end else begin
      down_sum[v] = add ? down_sum[v] + mag : down_sum[v] - mag;
    end
  endfunction

  function automatic void forecast_order(tick_tag_t t);
    int unsigned              v, w, p;
    logic signed [DIFF_W-1:0] move;
    longint unsigned          g, tot;
    order_word_t              o;
    v = t.venue;
    w = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : win_len);
    if (seen[v] == 0) begin
      last_px[v] = t.price;
      seen[v] = 1;
      return;
    end
    move = $signed({1'b0, t.price}) - $signed({1'b0, last_px[v]});
    last_px[v] = t.price;
    p = slot[v];
    if (p >= w) p = 0;
    if (seen[v] - 1 >= w) begin
      book_move(v, moves[v][p], 1'b0);
    end else begin
      seen[v]++;
    end
    moves[v][p] = move;
    book_move(v, move, 1'b1);
    p++;
    if (p >= w) p = 0;
    slot[v] = p;
    if (seen[v] - 1 < w) return;
    g   = up_sum[v];
    tot = g + down_sum[v];
    if (tot == 0) return;
    if (100 * g < buy_lvl * tot) begin
      o.side = SIDE_BUY;
    end else if (100 * g > sell_lvl * tot) begin
      o.side = SIDE_SELL;
    end else begin
      return;
    end
    order_count++;
    o.venue     = t.venue;
    o.symbol    = t.symbol;
    o.price     = t.price;
    o.size      = qty;
    o.number    = order_count;
    o.exch_ms   = t.exch_ms;
    o.ingest_ms = t.ingest_ms;
    orders_expected.insert(orders_expected.size(), o);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("order %0d: %s expected 0x%0h got 0x%0h", orders_checked, name, want, got);
    end
  endfunction

  // trending walk per venue, with flat spells and random jumps
  function automatic logic [31:0] next_walk(int unsigned v);
    longint px;
    int     roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      walk_px[v] = $urandom();
    end else if (roll >= 8) begin
      if ($urandom_range(0, 19) == 0) walk_drift[v] = int'($urandom_range(0, 2)) - 1;
      px = longint'(walk_px[v]) + walk_drift[v] * longint'($urandom_range(0, 1000))
           + longint'($urandom_range(0, 600)) - 300;
      if (px < 0) px = 0;
      else if (px > PX_MAX) px = PX_MAX;
      walk_px[v] = px[31:0];
    end
    return walk_px[v];
  endfunction

  task automatic push_tick(int unsigned v, logic [31:0] px, logic [15:0] sym,
                           logic [47:0] ex, logic [47:0] ing);
    tick_tag_t t;
    t.venue     = VENUE_FIELD_W'(v);
    t.price     = px;
    t.symbol    = sym;
    t.exch_ms   = ex;
    t.ingest_ms = ing;
    ticks_pending.insert(ticks_pending.size(), t);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_WINDOW_LENGTH: begin
        win_len = val[LEVEL_W-1:0];
        clear_windows();
      end
      REG_BUY_LEVEL:      buy_lvl  = val[LEVEL_W-1:0];
      REG_SELL_LEVEL:     sell_lvl = val[LEVEL_W-1:0];
      REG_ORDER_QUANTITY: qty      = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain: tick side read at posedge, expectations at negedge
  task automatic wait_idle();
    bit busy;
    do begin
      @(posedge clk);
      busy = (ticks_pending.size() != 0) || tick_ch.valid;
      @(negedge clk);
      busy = busy || (orders_expected.size() != 0);
    end while (busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      tick_ch.valid  <= 1'b0;
      order_ch.ready <= 1'b0;
    end else begin
      tick_hold = tick_ch.valid && !tick_fire;
      if (!tick_hold && ticks_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        cur_tick  = ticks_pending[0];
        ticks_pending.delete(0);
        tick_hold = 1'b1;
        tick_ch.venue_index      <= cur_tick.venue;
        tick_ch.symbol_tag       <= cur_tick.symbol;
        tick_ch.tick_price       <= cur_tick.price;
        tick_ch.exchange_time_ms <= cur_tick.exch_ms;
        tick_ch.ingest_time_ms   <= cur_tick.ingest_ms;
      end
      tick_ch.valid  <= tick_hold;
      order_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_channels
    order_word_t want;
    bit          order_fire;
    tick_fire  = !rst && tick_ch.valid && tick_ch.ready;
    order_fire = !rst && order_ch.valid && order_ch.ready;
    if (tick_fire) begin
      ticks_taken++;
      forecast_order(cur_tick);
    end
    if (order_fire) begin
      orders_checked++;
      if (orders_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("order %0d: no order expected, got side %0d venue %0d number %0d",
                   orders_checked, order_ch.order_side, order_ch.order_venue,
                   order_ch.order_number);
      end else begin
        want = orders_expected[0];
        orders_expected.delete(0);
        if (want.side == SIDE_BUY) buys_seen++;
        else sells_seen++;
        check_field("side", want.side, order_ch.order_side);
        check_field("venue", want.venue, order_ch.order_venue);
        check_field("symbol", want.symbol, order_ch.order_symbol);
        check_field("price", want.price, order_ch.order_price);
        check_field("size", want.size, order_ch.order_size);
        check_field("number", want.number, order_ch.order_number);
        check_field("exchange_ms", want.exch_ms, order_ch.order_exchange_ms);
        check_field("ingest_ms", want.ingest_ms, order_ch.order_ingest_ms);
      end
    end
    if (rst || tick_fire || order_fire) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d orders outstanding",
                 STALL_LIMIT, orders_expected.size());
        $display("windowed_rsi_order_signal regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned v;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    tick_ch.valid            = 1'b0;
    tick_ch.venue_index      = '0;
    tick_ch.symbol_tag       = '0;
    tick_ch.tick_price       = '0;
    tick_ch.exchange_time_ms = '0;
    tick_ch.ingest_time_ms   = '0;
    order_ch.ready           = 1'b0;
    win_len     = 14;
    buy_lvl     = 30;
    sell_lvl    = 70;
    qty         = '0;
    order_count = '0;
    clear_windows();
    src_idle_pct  = 11;
    sink_idle_pct = 63;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: warm-up ticks, pure gains, flat window, pure losses, balanced moves
    write_reg(REG_WINDOW_LENGTH, 2);
    write_reg(REG_BUY_LEVEL, 30);
    write_reg(REG_SELL_LEVEL, 70);
    write_reg(REG_ORDER_QUANTITY, 32'hFFFF_FFFF);
    for (int i = 0; i < 25; i++)
      push_tick(dir_venue[i], dir_px[i], (i % 2) ? 16'hFFFF : 16'h0000,
                (i % 2) ? 48'hFFFF_FFFF_FFFF : 48'h0, (i % 2) ? 48'h0 : 48'hFFFF_FFFF_FFFF);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        src_idle_pct  = 63;
        sink_idle_pct = 11;
      end else if (ph == 6) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_reg(REG_WINDOW_LENGTH, plan_win[ph]);
      write_reg(REG_BUY_LEVEL, plan_buy[ph]);
      write_reg(REG_SELL_LEVEL, plan_sell[ph]);
      write_reg(REG_ORDER_QUANTITY, (ph == 0) ? 32'hFFFF_FFFF : ((ph == 1) ? 32'h0 : $urandom()));
      for (int k = 0; k < NUM_VENUES; k++) begin
        walk_px[k]    = $urandom();
        walk_drift[k] = int'($urandom_range(0, 2)) - 1;
      end
      for (int n = 0; n < PHASE_TICKS; n++) begin
        v = $urandom_range(0, plan_span[ph] - 1);
        push_tick(v, next_walk(v), 16'($urandom()), 48'({$urandom(), $urandom()}),
                  48'({$urandom(), $urandom()}));
      end
      wait_idle();
    end

    $display("covered %0d ticks over 9 register settings and three handshake patterns",
             ticks_taken);
    $display("checked %0d orders (%0d buy, %0d sell), %0d field mismatches",
             orders_checked, buys_seen, sells_seen, mismatches);
    if (mismatches == 0 && orders_expected.size() == 0) begin
      $display("windowed_rsi_order_signal regression: pass");
    end else begin
      $display("windowed_rsi_order_signal regression: fail");
    end
    $finish;
  end

endmodule
